// ===== rtl/smx_pkg.sv =====
// Shared types, codes and sizes for the stack machine executor.
// No dependencies; the other files that use it refer to it by scoped names.
package smx_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 64;
    localparam int DEPTH_W     = 9;

    localparam logic [3:0] FN_START  = 4'd0;
    localparam logic [3:0] FN_PUSH   = 4'd1;
    localparam logic [3:0] FN_PUTC   = 4'd2;
    localparam logic [3:0] FN_PUTNUM = 4'd3;
    localparam logic [3:0] FN_ADD    = 4'd4;
    localparam logic [3:0] FN_SUB    = 4'd5;
    localparam logic [3:0] FN_MUL    = 4'd6;
    localparam logic [3:0] FN_DIV    = 4'd7;
    localparam logic [3:0] FN_DUP    = 4'd8;
    localparam logic [3:0] FN_SWAP   = 4'd9;
    localparam logic [3:0] FN_DROP   = 4'd10;
    localparam logic [3:0] FN_HALT   = 4'd11;

    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_CHAR    = 4'd1;
    localparam logic [3:0] ST_NUM     = 4'd2;
    localparam logic [3:0] ST_HALT    = 4'd3;
    localparam logic [3:0] ST_IGNORED = 4'd4;
    localparam logic [3:0] ST_UNDER   = 4'd5;
    localparam logic [3:0] ST_OVER    = 4'd6;
    localparam logic [3:0] ST_DIVZ    = 4'd7;
    localparam logic [3:0] ST_BADOP   = 4'd8;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [WORD_W-1:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic [3:0]               status;
        logic signed [WORD_W-1:0] out_value;
        logic [DEPTH_W-1:0]       stack_depth;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic md_start;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_md;
        logic md_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/smx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/smx_muldiv.sv =====
// Iterative multiply (three 32x32 partial products) and restoring divide.
// Depends on smx_pkg.
module smx_muldiv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            is_div,
    input  logic [smx_pkg::WORD_W-1:0]      op_a,
    input  logic [smx_pkg::WORD_W-1:0]      op_b,
    output logic                            done,
    output logic [smx_pkg::WORD_W-1:0]      result
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int H  = W / 2;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          div_reg, div_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  res_reg, res_next;
    logic [H-1:0]  mul_x, mul_y;
    logic [W-1:0]  prod;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          last;

    assign prod  = mul_x * mul_y;
    // divide: acc_reg is the remainder, a_reg the shifting quotient, b_reg the divisor
    assign trial = {acc_reg, a_reg[W-1]};
    assign diff  = trial - {1'b0, b_reg};
    assign last  = div_reg ? (cnt_reg == CW'(W - 1)) : (cnt_reg == CW'(2));

    always_comb
    begin
        mul_x = a_reg[H-1:0];
        mul_y = b_reg[H-1:0];
        if (cnt_reg == CW'(1))
        begin
            mul_y = b_reg[W-1:H];
        end
        else if (cnt_reg == CW'(2))
        begin
            mul_x = a_reg[W-1:H];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            div_next  = is_div;
            cnt_next  = '0;
            acc_next  = '0;
            neg_next  = op_a[W-1] ^ op_b[W-1];
            if (is_div)
            begin
                a_next = op_a[W-1] ? (W'(0) - op_a) : op_a;
                b_next = op_b[W-1] ? (W'(0) - op_b) : op_b;
            end
            else
            begin
                a_next = op_a;
                b_next = op_b;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (div_reg)
            begin
                a_next = {a_reg[W-2:0], ~diff[W]};
                acc_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
                if (last)
                begin
                    res_next = neg_reg ? (W'(0) - a_next) : a_next;
                end
            end
            else
            begin
                if (cnt_reg == '0)
                begin
                    acc_next = prod;
                end
                else
                begin
                    acc_next = acc_reg + {prod[H-1:0], H'(0)};
                end
                res_next = acc_next;
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/smx_datapath.sv =====
// Stack datapath: top-of-stack register, stack RAM below it, decode and
// result register. Depends on smx_pkg, smx_ram and smx_muldiv.
module smx_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  smx_pkg::dp_cmd_t    cmd,
    output smx_pkg::dp_stat_t   stat,
    input  smx_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output smx_pkg::out_item_t  out_item
);

    localparam int W  = smx_pkg::WORD_W;
    localparam int SW = smx_pkg::SP_W;
    localparam int AW = smx_pkg::ADDR_W;

    logic [3:0]             func_reg;
    logic [W-1:0]           imm_reg;
    logic [W-1:0]           tos_reg, tos_next;
    logic [SW-1:0]          sp_reg, sp_next;
    logic                   stopped_reg, stopped_next;
    logic                   out_valid_reg, out_valid_next;
    smx_pkg::out_item_t     out_reg;
    logic [3:0]             chk_st;
    logic [3:0]             res_st;
    logic [W-1:0]           res_val;
    logic [1:0]             need;
    logic                   grows, bad;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [W-1:0]           rd_data, wr_data;
    logic                   wr_en;
    logic                   md_done;
    logic [W-1:0]           md_result;
    logic                   out_free;

    assign rd_addr = AW'(sp_reg - SW'(2));

    smx_ram #(
        .WIDTH (W),
        .DEPTH (smx_pkg::STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smx_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .is_div (func_reg == smx_pkg::FN_DIV),
        .op_a   (rd_data),
        .op_b   (tos_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_comb
    begin
        need  = 2'd0;
        grows = 1'b0;
        bad   = 1'b0;
        unique case (func_reg)
            smx_pkg::FN_START, smx_pkg::FN_HALT: need = 2'd0;
            smx_pkg::FN_PUSH: grows = 1'b1;
            smx_pkg::FN_PUTC, smx_pkg::FN_PUTNUM, smx_pkg::FN_DROP: need = 2'd1;
            smx_pkg::FN_DUP:
            begin
                need  = 2'd1;
                grows = 1'b1;
            end
            smx_pkg::FN_ADD, smx_pkg::FN_SUB, smx_pkg::FN_MUL, smx_pkg::FN_DIV,
            smx_pkg::FN_SWAP: need = 2'd2;
            default: bad = 1'b1;
        endcase
    end

    // checks in order of precedence
    always_comb
    begin
        priority if (func_reg == smx_pkg::FN_START)
            chk_st = smx_pkg::ST_OK;
        else if (stopped_reg)
            chk_st = smx_pkg::ST_IGNORED;
        else if (bad)
            chk_st = smx_pkg::ST_BADOP;
        else if (sp_reg < SW'(need))
            chk_st = smx_pkg::ST_UNDER;
        else if (grows && (sp_reg >= SW'(smx_pkg::STACK_DEPTH)))
            chk_st = smx_pkg::ST_OVER;
        else if ((func_reg == smx_pkg::FN_DIV) && (tos_reg == '0))
            chk_st = smx_pkg::ST_DIVZ;
        else
            chk_st = smx_pkg::ST_OK;
    end

    always_comb
    begin
        sp_next      = sp_reg;
        tos_next     = tos_reg;
        stopped_next = stopped_reg;
        wr_en        = 1'b0;
        wr_addr      = AW'(sp_reg - SW'(1));
        wr_data      = tos_reg;
        res_st       = chk_st;
        res_val      = '0;
        if (func_reg == smx_pkg::FN_START)
        begin
            sp_next      = '0;
            stopped_next = 1'b0;
        end
        else if (chk_st == smx_pkg::ST_IGNORED)
        begin
            stopped_next = 1'b1;
        end
        else if (chk_st != smx_pkg::ST_OK)
        begin
            stopped_next = 1'b1;
        end
        else
        begin
            unique case (func_reg)
                smx_pkg::FN_PUSH:
                begin
                    wr_en    = (sp_reg != '0);
                    tos_next = imm_reg;
                    sp_next  = sp_reg + SW'(1);
                end
                smx_pkg::FN_DUP:
                begin
                    wr_en   = 1'b1;
                    sp_next = sp_reg + SW'(1);
                end
                smx_pkg::FN_PUTC:
                begin
                    res_st   = smx_pkg::ST_CHAR;
                    res_val  = {{(W-8){1'b0}}, tos_reg[7:0]};
                    tos_next = rd_data;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_PUTNUM:
                begin
                    res_st   = smx_pkg::ST_NUM;
                    res_val  = tos_reg;
                    tos_next = rd_data;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_DROP:
                begin
                    tos_next = rd_data;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_ADD:
                begin
                    tos_next = rd_data + tos_reg;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_SUB:
                begin
                    tos_next = rd_data - tos_reg;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_MUL, smx_pkg::FN_DIV:
                begin
                    tos_next = md_result;
                    sp_next  = sp_reg - SW'(1);
                end
                smx_pkg::FN_SWAP:
                begin
                    wr_en    = 1'b1;
                    wr_addr  = rd_addr;
                    tos_next = rd_data;
                end
                default:
                begin
                    res_st       = smx_pkg::ST_HALT;
                    stopped_next = 1'b1;
                end
            endcase
        end
        if (!cmd.commit)
        begin
            sp_next      = sp_reg;
            tos_next     = tos_reg;
            stopped_next = stopped_reg;
            wr_en        = 1'b0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
        if (cmd.load)
        begin
            func_reg <= in_item.func;
            imm_reg  <= in_item.immediate;
        end
        if (cmd.commit)
        begin
            out_reg.status      <= res_st;
            out_reg.out_value   <= res_val;
            out_reg.stack_depth <= smx_pkg::DEPTH_W'(sp_next);
        end
    end

    assign stat.need_md  = (chk_st == smx_pkg::ST_OK) &&
                           ((func_reg == smx_pkg::FN_MUL) || (func_reg == smx_pkg::FN_DIV));
    assign stat.md_done  = md_done;
    assign stat.out_free = out_free;
    assign out_valid     = out_valid_reg;
    assign out_item      = out_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SW'(smx_pkg::STACK_DEPTH))
        else $error("stack pointer beyond stack depth");
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result overwritten before transfer");
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (func_reg == smx_pkg::FN_START)) |=> (sp_reg == '0) && !stopped_reg)
        else $error("start did not clear the stack");
    a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && stopped_reg && (func_reg != smx_pkg::FN_START)) |=> $stable(sp_reg))
        else $error("stopped machine changed the stack");

endmodule

// ===== rtl/smx_ctrl.sv =====
// Sequencer for the stack machine: accept, execute, wait on mul/div, commit.
// Depends on smx_pkg.
module smx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output smx_pkg::dp_cmd_t   cmd,
    input  smx_pkg::dp_stat_t  stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MD   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.md_start = 1'b0;
        cmd.commit   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.need_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = S_MD;
                end
                else if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MD:
            begin
                if (stat.md_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("load did not enter execute");
    a_md_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.md_start |=> (state_reg == S_MD))
        else $error("mul/div start without wait");
    a_fin_from_md: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> ($past(state_reg) == S_MD || $past(state_reg) == S_FIN))
        else $error("finish entered without mul/div");

endmodule

// ===== rtl/stack_machine_executor_top.sv =====
// Top level of the stack machine executor: controller plus datapath.
// Depends on smx_pkg, smx_ctrl and smx_datapath.
//
// Usage:
//  - cmd channel (cmd_valid/cmd_stall/cmd_data) carries one decoded
//    instruction per transfer: func and a 64-bit immediate for push.
//  - res channel (res_valid/res_stall/res_data) returns exactly one result
//    per instruction: status, printed value and stack depth afterwards.
//  - Ordinary instructions pass through the transfer edge (the stack RAM
//    read of the entry beneath the top is issued then) and an execute
//    step that writes the result register. res_valid rises as that step
//    commits, and the controller is then back in idle for the next transfer.
//  - Multiply and divide add extra steps: multiply forms three 32x32 partial
//    products on one multiplier, divide forms one quotient bit per cycle for
//    all 64 bits; both then take a done pulse and a finish step.
//  - Reset empties the stack and sets the machine running; stack RAM
//    contents are not cleared and need no clearing pass, since only
//    entries below the stack pointer are ever used.
//  - When the receiver stalls, hold the result in the output register; the
//    next instruction can still be accepted and executed, and it waits at
//    its commit step until the register is free.
module stack_machine_executor_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  smx_pkg::in_item_t   cmd_data,
    output logic                res_valid,
    input  logic                res_stall,
    output smx_pkg::out_item_t  res_data
);

    smx_pkg::dp_cmd_t  dp_cmd;
    smx_pkg::dp_stat_t dp_stat;

    // sequencing: accept, execute, optional mul/div wait, commit
    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_valid),
        .in_stall (cmd_stall),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    // stack, arithmetic and the result register
    smx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .in_item   (cmd_data),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .out_item  (res_data)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for stack_machine_executor_top.
// Depends on smx_pkg and the executor RTL; predicts each result in place.
module testbench;

    localparam int W            = smx_pkg::WORD_W;
    localparam int EXPECT_DEPTH = 1024;
    localparam int ROW_DEPTH    = 512;
    localparam int RANDOM_ITEMS = 220;

    localparam logic [3:0] FN_UNKNOWN_LO = 4'd12;
    localparam logic [3:0] FN_UNKNOWN_HI = 4'd15;

    localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINUS_ONE = '1;

    logic                cmd_valid = 1'b0;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_stall;
    smx_pkg::in_item_t   cmd_data = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    smx_pkg::out_item_t  res_data;

    // predictor state: own copy of the stack
    logic [W-1:0]        model_stack [smx_pkg::STACK_DEPTH];
    int unsigned         model_sp = 0;
    bit                  model_stopped = 1'b0;

    // expected results in transfer order
    smx_pkg::out_item_t  expect_fifo [EXPECT_DEPTH];
    int unsigned         expect_wr = 0;
    int unsigned         expect_rd = 0;
    int unsigned         fail_count = 0;
    bit                  quiet_sender = 1'b0;
    bit                  quiet_receiver = 1'b0;

    // directed row: instruction plus an optional typed-in expectation
    typedef struct {
        logic [3:0]          func;
        logic [W-1:0]        immediate;
        bit                  has_literal;
        smx_pkg::out_item_t  literal;
    } directed_row_t;

    directed_row_t       rows [ROW_DEPTH];
    int unsigned         row_count = 0;

    always #4 clk = ~clk;

    stack_machine_executor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // Divide truncating toward zero, on magnitudes.
    function automatic logic [W-1:0] quotient_trunc(logic [W-1:0] a, logic [W-1:0] b);
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] q;
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        q  = ma / mb;
        return (a[W-1] != b[W-1]) ? -q : q;
    endfunction

    // Execute one instruction on the predictor state and return its result.
    function automatic smx_pkg::out_item_t execute_instruction(smx_pkg::in_item_t item);
        smx_pkg::out_item_t r;
        int unsigned        need;
        bit                 grows;
        logic [W-1:0]       a;
        logic [W-1:0]       b;
        r = '0;
        r.status = smx_pkg::ST_OK;
        need = 0;
        grows = 1'b0;
        if (item.func == smx_pkg::FN_START)
        begin
            model_sp = 0;
            model_stopped = 1'b0;
        end
        else if (model_stopped)
        begin
            r.status = smx_pkg::ST_IGNORED;
        end
        else
        begin
            case (item.func)
                smx_pkg::FN_PUSH: grows = 1'b1;
                smx_pkg::FN_PUTC, smx_pkg::FN_PUTNUM, smx_pkg::FN_DROP: need = 1;
                smx_pkg::FN_DUP:
                begin
                    need = 1;
                    grows = 1'b1;
                end
                smx_pkg::FN_ADD, smx_pkg::FN_SUB, smx_pkg::FN_MUL, smx_pkg::FN_DIV,
                smx_pkg::FN_SWAP: need = 2;
                smx_pkg::FN_HALT: ;
                default: r.status = smx_pkg::ST_BADOP;
            endcase
            if (r.status == smx_pkg::ST_OK && model_sp < need)
                r.status = smx_pkg::ST_UNDER;
            else if (r.status == smx_pkg::ST_OK && grows && model_sp >= smx_pkg::STACK_DEPTH)
                r.status = smx_pkg::ST_OVER;
            else if (r.status == smx_pkg::ST_OK && item.func == smx_pkg::FN_DIV
                     && model_stack[model_sp-1] == '0)
                r.status = smx_pkg::ST_DIVZ;

            if (r.status == smx_pkg::ST_OK)
            begin
                b = (need >= 1) ? model_stack[model_sp-1] : '0;
                a = (need >= 2) ? model_stack[model_sp-2] : '0;
                case (item.func)
                    smx_pkg::FN_PUSH:
                    begin
                        model_stack[model_sp] = item.immediate;
                        model_sp++;
                    end
                    smx_pkg::FN_PUTC:
                    begin
                        r.out_value = {56'd0, b[7:0]};
                        r.status = smx_pkg::ST_CHAR;
                        model_sp--;
                    end
                    smx_pkg::FN_PUTNUM:
                    begin
                        r.out_value = b;
                        r.status = smx_pkg::ST_NUM;
                        model_sp--;
                    end
                    smx_pkg::FN_ADD:
                    begin
                        model_stack[model_sp-2] = a + b;
                        model_sp--;
                    end
                    smx_pkg::FN_SUB:
                    begin
                        model_stack[model_sp-2] = a - b;
                        model_sp--;
                    end
                    smx_pkg::FN_MUL:
                    begin
                        model_stack[model_sp-2] = a * b;
                        model_sp--;
                    end
                    smx_pkg::FN_DIV:
                    begin
                        model_stack[model_sp-2] = quotient_trunc(a, b);
                        model_sp--;
                    end
                    smx_pkg::FN_DUP:
                    begin
                        model_stack[model_sp] = b;
                        model_sp++;
                    end
                    smx_pkg::FN_SWAP:
                    begin
                        model_stack[model_sp-2] = b;
                        model_stack[model_sp-1] = a;
                    end
                    smx_pkg::FN_DROP: model_sp--;
                    default:
                    begin
                        r.status = smx_pkg::ST_HALT;
                        model_stopped = 1'b1;
                    end
                endcase
            end
            else
            begin
                model_stopped = 1'b1;
            end
        end
        r.stack_depth = model_sp[smx_pkg::DEPTH_W-1:0];
        return r;
    endfunction

    // Random operand: extremes often, small values and full-range values too.
    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(5))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return MINUS_ONE;
            3: return W'($urandom_range(20)) - 64'd10;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Append one row to the directed table.
    task automatic add_row(logic [3:0] func, logic [W-1:0] imm, bit has_literal,
                           logic [3:0] status, logic [W-1:0] value, int unsigned depth);
        directed_row_t row;
        row.func                = func;
        row.immediate           = imm;
        row.has_literal         = has_literal;
        row.literal.status      = status;
        row.literal.out_value   = value;
        row.literal.stack_depth = depth[smx_pkg::DEPTH_W-1:0];
        rows[row_count] = row;
        row_count++;
    endtask

    // Row checked against the predictor only.
    task automatic add_op(logic [3:0] func, logic [W-1:0] imm);
        add_row(func, imm, 1'b0, smx_pkg::ST_OK, '0, 0);
    endtask

    // Present one instruction, holding it until the transfer happens.
    // Idle gaps are inserted before it unless the quiet stretch is on.
    task automatic send_instruction(smx_pkg::in_item_t item, bit has_literal,
                                    smx_pkg::out_item_t literal);
        smx_pkg::out_item_t predicted;
        while (!quiet_sender && $urandom_range(99) < 30)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= item;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predicted = execute_instruction(item);
        if (has_literal && predicted != literal)
        begin
            $display("%0t: table row disagrees with prediction: expected %h actual %h",
                     $time, literal, predicted);
            fail_count++;
        end
        expect_fifo[expect_wr % EXPECT_DEPTH] = has_literal ? literal : predicted;
        expect_wr++;
    endtask

    // Receiver: stall at random and check each transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expect_rd == expect_wr)
                begin
                    $display("%0t: expected no result actual %h", $time, res_data);
                    fail_count++;
                end
                else
                begin
                    smx_pkg::out_item_t want;
                    want = expect_fifo[expect_rd % EXPECT_DEPTH];
                    expect_rd++;
                    if (res_data.status != want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, res_data.status);
                        fail_count++;
                    end
                    if (res_data.out_value != want.out_value)
                    begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, want.out_value, res_data.out_value);
                        fail_count++;
                    end
                    if (res_data.stack_depth != want.stack_depth)
                    begin
                        $display("%0t: stack_depth expected %0d actual %0d",
                                 $time, want.stack_depth, res_data.stack_depth);
                        fail_count++;
                    end
                end
            end
            res_stall <= quiet_receiver ? 1'b0 : ($urandom_range(99) < 30);
        end
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4000000;
        $display("stack_machine_executor_top: mismatch");
        $finish;
    end

    initial
    begin
        smx_pkg::in_item_t item;
        int unsigned       i;
        int unsigned       pick;

        // Directed table: extremes, every operation and each error path.
        add_row(smx_pkg::FN_PUTNUM, '0, 1'b1, smx_pkg::ST_UNDER, '0, 0);
        add_row(smx_pkg::FN_PUSH, 64'd5, 1'b1, smx_pkg::ST_IGNORED, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(smx_pkg::FN_PUSH, MOST_NEG, 1'b1, smx_pkg::ST_OK, '0, 1);
        add_row(smx_pkg::FN_PUSH, MINUS_ONE, 1'b1, smx_pkg::ST_OK, '0, 2);
        add_row(smx_pkg::FN_DIV, '0, 1'b1, smx_pkg::ST_OK, '0, 1);
        add_row(smx_pkg::FN_PUTNUM, '0, 1'b1, smx_pkg::ST_NUM, MOST_NEG, 0);
        add_row(smx_pkg::FN_PUSH, 64'h141, 1'b1, smx_pkg::ST_OK, '0, 1);
        add_row(smx_pkg::FN_PUTC, '0, 1'b1, smx_pkg::ST_CHAR, 64'h41, 0);
        add_row(smx_pkg::FN_PUSH, 64'd7, 1'b1, smx_pkg::ST_OK, '0, 1);
        add_row(smx_pkg::FN_PUSH, '0, 1'b1, smx_pkg::ST_OK, '0, 2);
        add_row(smx_pkg::FN_DIV, '0, 1'b1, smx_pkg::ST_DIVZ, '0, 2);
        add_row(smx_pkg::FN_DUP, '0, 1'b1, smx_pkg::ST_IGNORED, '0, 2);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_op(smx_pkg::FN_PUSH, 64'd0 - 64'd12);
        add_op(smx_pkg::FN_PUSH, 64'd5);
        add_op(smx_pkg::FN_DIV, '0);
        add_op(smx_pkg::FN_PUTNUM, '0);
        add_op(smx_pkg::FN_PUSH, MOST_POS);
        add_op(smx_pkg::FN_PUSH, 64'd1);
        add_op(smx_pkg::FN_ADD, '0);
        add_op(smx_pkg::FN_PUSH, 64'd3);
        add_op(smx_pkg::FN_MUL, '0);
        add_op(smx_pkg::FN_PUSH, MOST_NEG);
        add_op(smx_pkg::FN_SUB, '0);
        add_op(smx_pkg::FN_PUSH, 64'd9);
        add_op(smx_pkg::FN_SWAP, '0);
        add_op(smx_pkg::FN_DUP, '0);
        add_op(smx_pkg::FN_MUL, '0);
        add_op(smx_pkg::FN_DROP, '0);
        add_op(smx_pkg::FN_PUTNUM, '0);
        add_row(smx_pkg::FN_ADD, '0, 1'b1, smx_pkg::ST_UNDER, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(smx_pkg::FN_PUSH, 64'd1, 1'b1, smx_pkg::ST_OK, '0, 1);
        add_row(smx_pkg::FN_SWAP, '0, 1'b1, smx_pkg::ST_UNDER, '0, 1);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(smx_pkg::FN_DROP, '0, 1'b1, smx_pkg::ST_UNDER, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(smx_pkg::FN_HALT, '0, 1'b1, smx_pkg::ST_HALT, '0, 0);
        add_row(smx_pkg::FN_PUSH, 64'd1, 1'b1, smx_pkg::ST_IGNORED, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(FN_UNKNOWN_LO, '0, 1'b1, smx_pkg::ST_BADOP, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        add_row(FN_UNKNOWN_HI, '0, 1'b1, smx_pkg::ST_BADOP, '0, 0);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);
        // fill the stack to one below full, then reach full and overflow
        for (i = 0; i < smx_pkg::STACK_DEPTH - 1; i++)
            add_op(smx_pkg::FN_PUSH, random_operand());
        add_row(smx_pkg::FN_DUP, '0, 1'b1, smx_pkg::ST_OK, '0, smx_pkg::STACK_DEPTH);
        add_row(smx_pkg::FN_PUSH, '0, 1'b1, smx_pkg::ST_OVER, '0, smx_pkg::STACK_DEPTH);
        add_row(smx_pkg::FN_DUP, '0, 1'b1, smx_pkg::ST_IGNORED, '0, smx_pkg::STACK_DEPTH);
        add_row(smx_pkg::FN_START, '0, 1'b1, smx_pkg::ST_OK, '0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < row_count; i++)
        begin
            item.func      = rows[i].func;
            item.immediate = rows[i].immediate;
            send_instruction(item, rows[i].has_literal, rows[i].literal);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 40)
            begin
                // hold off until every expected result has come
                cmd_valid <= 1'b0;
                wait (expect_rd == expect_wr);
                @(posedge clk);
            end
            quiet_sender   = (i >= 80) && (i < 140);
            quiet_receiver = (i >= 80) && (i < 140);
            pick = $urandom_range(99);
            if (pick < 6)
                item.func = smx_pkg::FN_START;
            else if (pick < 8)
                item.func = FN_UNKNOWN_LO + 4'($urandom_range(3));
            else if (pick < 10)
                item.func = smx_pkg::FN_HALT;
            else if (pick < 40)
                item.func = smx_pkg::FN_PUSH;
            else
                item.func = 4'($urandom_range(10, 2));
            item.immediate = random_operand();
            send_instruction(item, 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        wait (expect_rd == expect_wr);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("stack_machine_executor_top: match");
        else
            $display("stack_machine_executor_top: mismatch");
        $finish;
    end

endmodule

// ===== stack_machine_executor_top.f =====
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_muldiv.sv
rtl/smx_datapath.sv
rtl/smx_ctrl.sv
rtl/stack_machine_executor_top.sv
verif/testbench.sv
